// ===== rtl/core/qslerp_pkg.sv =====
`timescale 1ns / 1ps
package qslerp_pkg;

    localparam int CW = 34;
    localparam int S1W = 57;
    localparam int S1_CELLS = 29;
    localparam int S2W = 63;
    localparam int S2_CELLS = 32;
    localparam int RW = 46;
    localparam int DW = 32;
    localparam int QW = 15;
    localparam int VW = 51;
    localparam int WW = 31;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] DOT_ONE = 34'sd268435456;

    localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
        34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
        34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
        34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
        34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
        34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
    };

    typedef enum logic [1:0] {
        MODE_PASS_A,
        MODE_PASS_B,
        MODE_BLEND
    } mode_t;

    typedef struct packed {
        logic signed [15:0] a_w;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] blend;
    } slerp_in_t;

    typedef struct packed {
        logic signed [15:0] out_w;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               degenerate;
    } slerp_out_t;

    typedef struct packed {
        logic [3:0][15:0]   a;
        logic [3:0][15:0]   b;
        logic [13:0]        t;
        mode_t              mode;
        logic [3:0][15:0]   direct;
        logic signed [29:0] dot;
        logic               deg;
        logic [3:0][WW-1:0] wmag;
        logic [3:0]         wneg;
    } side_t;

    function automatic logic [15:0] sat16(input logic signed [15:0] v);
        logic [15:0] r;
        if (v > ONE_Q14)
        begin
            r = ONE_Q14;
        end
        else if (v < -ONE_Q14)
        begin
            r = -ONE_Q14;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/quaternion_slerp.sv =====
`timescale 1ns / 1ps
// Quaternion slerp, Q2.14 in and out.
// Drive operands and pulse start; busy stays low, so a transfer happens at
// every clock edge with start high and a new pair may enter in every cycle.
// Each pair runs through a fixed row of cells: dot product and clamp, a
// 29-cell square root for sin(omega), a vectoring CORDIC for omega, the
// blend multiply, two rotation CORDICs for the sines, the weighted sum,
// shift and square, a 32-cell square root for the norm and four 15-cell
// dividers. Each cell works on one pair per cycle and hands it on.
// done pulses for one cycle with result valid; one result per cycle at full
// rate, in transfer order.
// The receiver cannot stall: a result is shown for its single cycle only.
// Reset clears the valid bits of every stage; items in flight are dropped
// and no done pulse appears until new work arrives.
module quaternion_slerp #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  qslerp_pkg::slerp_in_t  operands,
    output logic                   done,
    output qslerp_pkg::slerp_out_t result
);
    import qslerp_pkg::*;

    localparam int NC = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int ST_DOT = 2;
    localparam int ST_RAD = 4;
    localparam int ST_S = ST_RAD + S1_CELLS;
    localparam int ST_V0 = ST_S + 1;
    localparam int ST_VEND = ST_V0 + NC;
    localparam int ST_OMEGA = ST_VEND + 1;
    localparam int ST_R0 = ST_OMEGA + 3;
    localparam int ST_REND = ST_R0 + NC;
    localparam int ST_W = ST_REND + 4;
    localparam int ST_SQW = ST_W + 1;
    localparam int ST_SUM = ST_SQW + 1;
    localparam int ST_NORM = ST_SUM + S2_CELLS;
    localparam int ST_DEND = ST_NORM + 1 + QW;

    logic [ST_DEND:0] valid_reg;
    logic             done_reg;
    slerp_out_t       result_reg;
    slerp_out_t       result_next;

    side_t side_reg [0:ST_DEND];
    side_t side_in_next;
    side_t side_dot_next;
    side_t side_sqw_next;

    logic signed [31:0]    prod_reg [4];
    logic signed [33:0]    dsum;
    logic signed [59:0]    sq_next;
    logic [S1W-1:0]        sq_reg;
    logic [S1W-1:0]        rad_reg;
    logic [S1W-1:0]        s1_rem [0:S1_CELLS];
    logic [S1W-1:0]        s1_root [0:S1_CELLS];
    logic signed [CW-1:0]  dot_ext;
    logic signed [CW-1:0]  xq;
    logic signed [CW-1:0]  yq;
    logic signed [CW-1:0]  vx0_next, vy0_next, vz0_next;
    logic signed [CW-1:0]  vx [0:NC];
    logic signed [CW-1:0]  vy [0:NC];
    logic signed [CW-1:0]  vz [0:NC];
    logic [31:0]           omega_next;
    logic [31:0]           omega_reg;
    logic [31:0]           omega_d_reg;
    logic [45:0]           ot_reg;
    logic [31:0]           ta_reg;
    logic [31:0]           tb_reg;
    logic signed [CW-1:0]  zta, ztb;
    logic signed [CW-1:0]  ax [0:NC];
    logic signed [CW-1:0]  ay [0:NC];
    logic signed [CW-1:0]  az [0:NC];
    logic signed [CW-1:0]  bx [0:NC];
    logic signed [CW-1:0]  by [0:NC];
    logic signed [CW-1:0]  bz [0:NC];
    logic signed [CW-1:0]  ca, cb;
    logic signed [49:0]    pa_reg [4];
    logic signed [49:0]    pb_reg [4];
    logic signed [VW-1:0]  v_reg [4];
    logic signed [VW-1:0]  vd_reg [4];
    logic [VW-1:0]         vabs [4];
    logic [VW-1:0]         vor;
    logic [4:0]            sh_next;
    logic [4:0]            sh_reg;
    logic signed [VW-1:0]  wfull [4];
    logic signed [WW-1:0]  w_reg [4];
    logic signed [61:0]    sqw_next [4];
    logic [61:0]           sqw_reg [4];
    logic [S2W-1:0]        sum_reg;
    logic [S2W-1:0]        s2_rem [0:S2_CELLS];
    logic [S2W-1:0]        s2_root [0:S2_CELLS];
    logic [DW-1:0]         norm;
    logic [DW-1:0]         den;
    logic [RW-1:0]         dv_rem [4][0:QW];
    logic [QW-1:0]         dv_quo [4][0:QW];
    logic [DW-1:0]         dv_den [4][0:QW];
    logic [15:0]           qv;

    assign busy = 1'b0;
    assign done = done_reg;
    assign result = result_reg;

    always_comb
    begin
        side_in_next = '0;
        side_in_next.a = {operands.a_z, operands.a_y, operands.a_x, operands.a_w};
        side_in_next.b = {operands.b_z, operands.b_y, operands.b_x, operands.b_w};
        side_in_next.t = operands.blend[13:0];
        if (operands.blend <= 16'sd0)
        begin
            side_in_next.mode = MODE_PASS_A;
        end
        else if (operands.blend >= ONE_Q14)
        begin
            side_in_next.mode = MODE_PASS_B;
        end
        else
        begin
            side_in_next.mode = MODE_BLEND;
        end
        for (int k = 0; k < 4; k++)
        begin
            side_in_next.direct[k] = (side_in_next.mode == MODE_PASS_B) ?
                sat16(side_in_next.b[k]) : sat16(side_in_next.a[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[ST_DEND-1:0], start & ~busy};
            done_reg  <= valid_reg[ST_DEND];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in_next;
    end

    for (genvar i = 1; i <= ST_DEND; i++)
    begin : g_side
        if (i == ST_DOT)
        begin : g_dot
            always_ff @(posedge clk)
            begin
                side_reg[i] <= side_dot_next;
            end
        end
        else if (i == ST_SQW)
        begin : g_sqw
            always_ff @(posedge clk)
            begin
                side_reg[i] <= side_sqw_next;
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= $signed(side_reg[0].a[k]) * $signed(side_reg[0].b[k]);
        end
    end

    always_comb
    begin
        dsum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        side_dot_next = side_reg[1];
        if (dsum > DOT_ONE)
        begin
            side_dot_next.dot = DOT_ONE[29:0];
        end
        else if (dsum < -DOT_ONE)
        begin
            side_dot_next.dot = -DOT_ONE[29:0];
        end
        else
        begin
            side_dot_next.dot = dsum[29:0];
        end
        side_dot_next.deg = (side_dot_next.dot == DOT_ONE[29:0]) ||
                            (side_dot_next.dot == -DOT_ONE[29:0]);
    end

    assign sq_next = side_reg[ST_DOT].dot * side_reg[ST_DOT].dot;

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next[S1W-1:0];
        rad_reg <= (S1W'(1) << (S1W - 1)) - sq_reg;
    end

    assign s1_rem[0]  = rad_reg;
    assign s1_root[0] = '0;

    for (genvar j = 0; j < S1_CELLS; j++)
    begin : g_s1
        qslerp_sqrt_cell #(.W(S1W), .K(S1_CELLS - 1 - j)) u_cell (
            .clk      (clk),
            .rem      (s1_rem[j]),
            .root     (s1_root[j]),
            .rem_reg  (s1_rem[j+1]),
            .root_reg (s1_root[j+1])
        );
    end

    always_comb
    begin
        dot_ext = CW'(side_reg[ST_S].dot);
        xq = dot_ext <<< 2;
        yq = CW'(s1_root[S1_CELLS]) <<< 2;
        if (dot_ext < 0)
        begin
            vx0_next = yq;
            vy0_next = -xq;
            vz0_next = HALF_PI_Q30;
        end
        else
        begin
            vx0_next = xq;
            vy0_next = yq;
            vz0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        vx[0] <= vx0_next;
        vy[0] <= vy0_next;
        vz[0] <= vz0_next;
    end

    for (genvar j = 0; j < NC; j++)
    begin : g_vec
        qslerp_cordic_cell #(.I(j), .ROT(1'b0)) u_cell (
            .clk   (clk),
            .x     (vx[j]),
            .y     (vy[j]),
            .z     (vz[j]),
            .x_reg (vx[j+1]),
            .y_reg (vy[j+1]),
            .z_reg (vz[j+1])
        );
    end

    always_comb
    begin
        if (vz[NC] < 0)
        begin
            omega_next = '0;
        end
        else if (vz[NC] > PI_Q30)
        begin
            omega_next = PI_Q30[31:0];
        end
        else
        begin
            omega_next = vz[NC][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        omega_reg   <= omega_next;
        ot_reg      <= 46'(omega_reg) * 46'(side_reg[ST_OMEGA].t);
        omega_d_reg <= omega_reg;
        tb_reg      <= ot_reg[45:14];
        ta_reg      <= omega_d_reg - ot_reg[45:14];
    end

    always_comb
    begin
        zta = CW'(ta_reg);
        ztb = CW'(tb_reg);
        if (zta > HALF_PI_Q30)
        begin
            zta = PI_Q30 - zta;
        end
        if (ztb > HALF_PI_Q30)
        begin
            ztb = PI_Q30 - ztb;
        end
    end

    assign ax[0] = ONE_Q30;
    assign ay[0] = '0;
    assign bx[0] = ONE_Q30;
    assign by[0] = '0;

    always_ff @(posedge clk)
    begin
        az[0] <= zta;
        bz[0] <= ztb;
    end

    for (genvar j = 0; j < NC; j++)
    begin : g_rot
        qslerp_cordic_cell #(.I(j), .ROT(1'b1)) u_cell_a (
            .clk   (clk),
            .x     (ax[j]),
            .y     (ay[j]),
            .z     (az[j]),
            .x_reg (ax[j+1]),
            .y_reg (ay[j+1]),
            .z_reg (az[j+1])
        );
        qslerp_cordic_cell #(.I(j), .ROT(1'b1)) u_cell_b (
            .clk   (clk),
            .x     (bx[j]),
            .y     (by[j]),
            .z     (bz[j]),
            .x_reg (bx[j+1]),
            .y_reg (by[j+1]),
            .z_reg (bz[j+1])
        );
    end

    always_comb
    begin
        if (side_reg[ST_REND].deg)
        begin
            ca = CW'(ONE_Q14) - CW'(side_reg[ST_REND].t);
            cb = CW'(side_reg[ST_REND].t);
        end
        else
        begin
            ca = ay[NC];
            cb = by[NC];
        end
    end

    always_comb
    begin
        vor = '0;
        for (int k = 0; k < 4; k++)
        begin
            vabs[k] = v_reg[k][VW-1] ? VW'(-v_reg[k]) : VW'(v_reg[k]);
            vor = vor | vabs[k];
        end
        sh_next = '0;
        for (int p = 30; p < VW; p++)
        begin
            if (vor[p])
            begin
                sh_next = 5'(p - 29);
            end
        end
    end

    always_comb
    begin
        side_sqw_next = side_reg[ST_W];
        for (int k = 0; k < 4; k++)
        begin
            wfull[k] = vd_reg[k] >>> sh_reg;
            sqw_next[k] = w_reg[k] * w_reg[k];
            side_sqw_next.wneg[k] = w_reg[k][WW-1];
            side_sqw_next.wmag[k] = w_reg[k][WW-1] ? WW'(-w_reg[k]) : WW'(w_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            pa_reg[k]  <= ca * $signed(side_reg[ST_REND].a[k]);
            pb_reg[k]  <= cb * $signed(side_reg[ST_REND].b[k]);
            v_reg[k]   <= VW'(pa_reg[k]) + VW'(pb_reg[k]);
            vd_reg[k]  <= v_reg[k];
            w_reg[k]   <= wfull[k][WW-1:0];
            sqw_reg[k] <= sqw_next[k];
        end
        sh_reg  <= sh_next;
        sum_reg <= S2W'(sqw_reg[0]) + S2W'(sqw_reg[1]) + S2W'(sqw_reg[2]) + S2W'(sqw_reg[3]);
    end

    assign s2_rem[0]  = sum_reg;
    assign s2_root[0] = '0;

    for (genvar j = 0; j < S2_CELLS; j++)
    begin : g_s2
        qslerp_sqrt_cell #(.W(S2W), .K(S2_CELLS - 1 - j)) u_cell (
            .clk      (clk),
            .rem      (s2_rem[j]),
            .root     (s2_root[j]),
            .rem_reg  (s2_rem[j+1]),
            .root_reg (s2_root[j+1])
        );
    end

    assign norm = s2_root[S2_CELLS][DW-1:0];
    assign den  = (norm == '0) ? DW'(1) : norm;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            dv_rem[k][0] <= (RW'(side_reg[ST_NORM].wmag[k]) << 14) + RW'(den >> 1);
            dv_quo[k][0] <= '0;
            dv_den[k][0] <= den;
        end
        for (genvar j = 0; j < QW; j++)
        begin : g_div
            qslerp_div_cell #(.J(QW - 1 - j)) u_cell (
                .clk     (clk),
                .rem     (dv_rem[k][j]),
                .quo     (dv_quo[k][j]),
                .den     (dv_den[k][j]),
                .rem_reg (dv_rem[k][j+1]),
                .quo_reg (dv_quo[k][j+1]),
                .den_reg (dv_den[k][j+1])
            );
        end
    end

    always_comb
    begin
        result_next = '0;
        qv = '0;
        if (side_reg[ST_DEND].mode != MODE_BLEND)
        begin
            result_next.out_w = side_reg[ST_DEND].direct[0];
            result_next.out_x = side_reg[ST_DEND].direct[1];
            result_next.out_y = side_reg[ST_DEND].direct[2];
            result_next.out_z = side_reg[ST_DEND].direct[3];
        end
        else
        begin
            result_next.degenerate = side_reg[ST_DEND].deg;
            for (int k = 0; k < 4; k++)
            begin
                qv = 16'(dv_quo[k][QW]);
                if (side_reg[ST_DEND].wneg[k])
                begin
                    qv = -qv;
                end
                case (k)
                    0: result_next.out_w = qv;
                    1: result_next.out_x = qv;
                    2: result_next.out_y = qv;
                    default: result_next.out_z = qv;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/qslerp_sqrt_cell.sv =====
`timescale 1ns / 1ps
module qslerp_sqrt_cell #(
    parameter int W = 57,
    parameter int K = 0
) (
    input  logic         clk,
    input  logic [W-1:0] rem,
    input  logic [W-1:0] root,
    output logic [W-1:0] rem_reg,
    output logic [W-1:0] root_reg
);

    localparam logic [W:0] BIT = (W+1)'(1) << (2 * K);

    logic [W:0] trial;

    assign trial = {1'b0, root} + BIT;

    always_ff @(posedge clk)
    begin
        if ({1'b0, rem} >= trial)
        begin
            rem_reg  <= rem - trial[W-1:0];
            root_reg <= (root >> 1) + BIT[W-1:0];
        end
        else
        begin
            rem_reg  <= rem;
            root_reg <= root >> 1;
        end
    end

endmodule

// ===== rtl/core/qslerp_cordic_cell.sv =====
`timescale 1ns / 1ps
module qslerp_cordic_cell #(
    parameter int I = 0,
    parameter bit ROT = 1'b0
) (
    input  logic                           clk,
    input  logic signed [qslerp_pkg::CW-1:0] x,
    input  logic signed [qslerp_pkg::CW-1:0] y,
    input  logic signed [qslerp_pkg::CW-1:0] z,
    output logic signed [qslerp_pkg::CW-1:0] x_reg,
    output logic signed [qslerp_pkg::CW-1:0] y_reg,
    output logic signed [qslerp_pkg::CW-1:0] z_reg
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 up_dir;

    assign xs = x >>> I;
    assign ys = y >>> I;
    assign up_dir = ROT ? z[CW-1] : ~y[CW-1];

    always_ff @(posedge clk)
    begin
        if (up_dir)
        begin
            x_reg <= x + ys;
            y_reg <= y - xs;
            z_reg <= z + ATAN_Q30[I];
        end
        else
        begin
            x_reg <= x - ys;
            y_reg <= y + xs;
            z_reg <= z - ATAN_Q30[I];
        end
    end

endmodule

// ===== rtl/core/qslerp_div_cell.sv =====
`timescale 1ns / 1ps
module qslerp_div_cell #(
    parameter int J = 0
) (
    input  logic                      clk,
    input  logic [qslerp_pkg::RW-1:0] rem,
    input  logic [qslerp_pkg::QW-1:0] quo,
    input  logic [qslerp_pkg::DW-1:0] den,
    output logic [qslerp_pkg::RW-1:0] rem_reg,
    output logic [qslerp_pkg::QW-1:0] quo_reg,
    output logic [qslerp_pkg::DW-1:0] den_reg
);
    import qslerp_pkg::*;

    logic [RW-1:0] dsh;

    assign dsh = RW'(den) << J;

    always_ff @(posedge clk)
    begin
        den_reg <= den;
        if (rem >= dsh)
        begin
            rem_reg <= rem - dsh;
            quo_reg <= quo | (QW'(1) << J);
        end
        else
        begin
            rem_reg <= rem;
            quo_reg <= quo;
        end
    end

endmodule
